// File: rtl/afx_pkg.sv
// Shared types, constants and microprogram table for the audio effect filter.
// Used by afx_sequencer, afx_datapath and audio_effect_filter_top.
package afx_pkg;

    // Filter modes
    localparam logic [1:0] MODE_PASS  = 2'd0;
    localparam logic [1:0] MODE_PHONE = 2'd1;
    localparam logic [1:0] MODE_WATER = 2'd2;
    localparam logic [1:0] MODE_CAVE  = 2'd3;

    // Configuration register indexes
    localparam logic [1:0] REG_FILTER_MODE   = 2'd0;
    localparam logic [1:0] REG_CHANNEL_COUNT = 2'd1;
    localparam logic [1:0] REG_SAMPLE_RATE   = 2'd2;

    // Reset values of the configuration registers
    localparam logic [1:0]  RST_FILTER_MODE   = MODE_PASS;
    localparam logic [3:0]  RST_CHANNEL_COUNT = 4'd2;
    localparam logic [16:0] RST_SAMPLE_RATE   = 17'd48000;

    // Q4.14 coefficients
    localparam logic [17:0] ALPHA_PHONE = 18'd5898;
    localparam logic [17:0] ALPHA_WATER = 18'd1638;
    localparam logic [17:0] GAIN_PHONE  = 18'd34406;
    localparam logic [17:0] GAIN_CAVE   = 18'd4588;

    // Low-pass level limits, Q1.23
    localparam logic signed [26:0] LP_MAX = 27'sd8388607;
    localparam logic signed [26:0] LP_MIN = -27'sd8388608;

    // Multiplier operand selection
    typedef enum logic [2:0] {
        MUL_NONE,
        MUL_ALPHA_PHONE,
        MUL_ALPHA_WATER,
        MUL_GAIN_PHONE,
        MUL_FRAMES,
        MUL_GAIN_CAVE
    } mul_sel_t;

    // Post-multiply operation
    typedef enum logic [2:0] {
        ALU_NONE,
        ALU_LP_UPDATE,
        ALU_ECHO_READ,
        ALU_Y_PASS,
        ALU_Y_PHONE,
        ALU_Y_WATER,
        ALU_Y_CAVE
    } alu_op_t;

    // Sequencing of the step counter
    typedef enum logic {
        JMP_NEXT,
        JMP_DISPATCH
    } jmp_t;

    typedef logic [3:0] step_t;

    // Program addresses
    localparam step_t STEP_IDLE      = 4'd0;
    localparam step_t STEP_PASS_OUT  = 4'd1;
    localparam step_t STEP_PH_MUL1   = 4'd2;
    localparam step_t STEP_PH_LP     = 4'd3;
    localparam step_t STEP_PH_MUL2   = 4'd4;
    localparam step_t STEP_PH_OUT    = 4'd5;
    localparam step_t STEP_WA_MUL    = 4'd6;
    localparam step_t STEP_WA_LP     = 4'd7;
    localparam step_t STEP_WA_OUT    = 4'd8;
    localparam step_t STEP_CV_MUL1   = 4'd9;
    localparam step_t STEP_CV_READ   = 4'd10;
    localparam step_t STEP_CV_MUL2   = 4'd11;
    localparam step_t STEP_CV_OUT    = 4'd12;

    // One control word
    typedef struct packed {
        mul_sel_t mul_sel;
        alu_op_t  alu_op;
        jmp_t     jmp;
        logic     finish;
        step_t    next_step;
    } ucode_t;

    // Sequencer to datapath controls
    typedef struct packed {
        mul_sel_t mul_sel;
        alu_op_t  alu_op;
        logic     accept;
        logic     commit;
    } ctrl_t;

    // Configuration register set
    typedef struct packed {
        logic [1:0]  filter_mode;
        logic [3:0]  channel_count;
        logic [16:0] sample_rate;
    } cfg_t;

    // Microprogram ROM
    function automatic ucode_t ucode_word(input step_t s);
        ucode_t w;
        unique case (s)
            STEP_IDLE:     w = '{MUL_NONE,        ALU_NONE,      JMP_DISPATCH, 1'b0, STEP_IDLE};
            STEP_PASS_OUT: w = '{MUL_NONE,        ALU_Y_PASS,    JMP_NEXT,     1'b1, STEP_IDLE};
            STEP_PH_MUL1:  w = '{MUL_ALPHA_PHONE, ALU_NONE,      JMP_NEXT,     1'b0, STEP_PH_LP};
            STEP_PH_LP:    w = '{MUL_NONE,        ALU_LP_UPDATE, JMP_NEXT,     1'b0, STEP_PH_MUL2};
            STEP_PH_MUL2:  w = '{MUL_GAIN_PHONE,  ALU_NONE,      JMP_NEXT,     1'b0, STEP_PH_OUT};
            STEP_PH_OUT:   w = '{MUL_NONE,        ALU_Y_PHONE,   JMP_NEXT,     1'b1, STEP_IDLE};
            STEP_WA_MUL:   w = '{MUL_ALPHA_WATER, ALU_NONE,      JMP_NEXT,     1'b0, STEP_WA_LP};
            STEP_WA_LP:    w = '{MUL_NONE,        ALU_LP_UPDATE, JMP_NEXT,     1'b0, STEP_WA_OUT};
            STEP_WA_OUT:   w = '{MUL_NONE,        ALU_Y_WATER,   JMP_NEXT,     1'b1, STEP_IDLE};
            STEP_CV_MUL1:  w = '{MUL_FRAMES,      ALU_NONE,      JMP_NEXT,     1'b0, STEP_CV_READ};
            STEP_CV_READ:  w = '{MUL_NONE,        ALU_ECHO_READ, JMP_NEXT,     1'b0, STEP_CV_MUL2};
            STEP_CV_MUL2:  w = '{MUL_GAIN_CAVE,   ALU_NONE,      JMP_NEXT,     1'b0, STEP_CV_OUT};
            STEP_CV_OUT:   w = '{MUL_NONE,        ALU_Y_CAVE,    JMP_NEXT,     1'b1, STEP_IDLE};
            default:       w = '{MUL_NONE,        ALU_NONE,      JMP_NEXT,     1'b0, STEP_IDLE};
        endcase
        return w;
    endfunction

    // Entry point of each mode's routine
    function automatic step_t dispatch_step(input logic [1:0] mode);
        step_t s;
        unique case (mode)
            MODE_PASS:  s = STEP_PASS_OUT;
            MODE_PHONE: s = STEP_PH_MUL1;
            MODE_WATER: s = STEP_WA_MUL;
            MODE_CAVE:  s = STEP_CV_MUL1;
            default:    s = STEP_PASS_OUT;
        endcase
        return s;
    endfunction

    // Saturate a wide signed value to Q1.15
    function automatic logic signed [15:0] sat16(input logic signed [42:0] v);
        logic signed [15:0] r;
        if (v > 43'sd32767)
        begin
            r = 16'sh7FFF;
        end
        else if (v < -43'sd32768)
        begin
            r = -16'sh8000;
        end
        else
        begin
            r = v[15:0];
        end
        return r;
    endfunction

endpackage

// File: rtl/afx_sequencer.sv
// Step counter and microprogram fetch for the audio effect filter.
// Depends on afx_pkg (control word table, ctrl_t).
module afx_sequencer (
    input  logic             clk,
    input  logic             rst_n,
    input  logic [1:0]       filter_mode,
    input  logic             in_valid,
    output logic             in_stall,
    input  logic             out_hold,
    output afx_pkg::ctrl_t   ctrl
);

    afx_pkg::step_t  step_reg;
    afx_pkg::step_t  step_next;
    afx_pkg::ucode_t word;
    logic            accept;
    logic            commit;

    // Fetch the current control word
    assign word = afx_pkg::ucode_word(step_reg);

    // Input is taken only at the dispatch step
    assign in_stall = (word.jmp != afx_pkg::JMP_DISPATCH);
    assign accept   = (word.jmp == afx_pkg::JMP_DISPATCH) && in_valid;
    // A finishing step waits while the output register is still full and stalled
    assign commit   = word.finish && !out_hold;

    // Next step
    always_comb
    begin
        if (word.jmp == afx_pkg::JMP_DISPATCH)
        begin
            step_next = accept ? afx_pkg::dispatch_step(filter_mode) : step_reg;
        end
        else if (word.finish && out_hold)
        begin
            step_next = step_reg;
        end
        else
        begin
            step_next = word.next_step;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            step_reg <= afx_pkg::STEP_IDLE;
        end
        else
        begin
            step_reg <= step_next;
        end
    end

    // Controls to the datapath
    always_comb
    begin
        ctrl.mul_sel = word.mul_sel;
        ctrl.alu_op  = word.alu_op;
        ctrl.accept  = accept;
        ctrl.commit  = commit;
    end

endmodule

// File: rtl/afx_datapath.sv
// Datapath of the audio effect filter: shared multiplier, per-channel
// low-pass state, echo memory and output register. Depends on afx_pkg.
module afx_datapath #(
    parameter int MAX_CHANNELS = 8,
    parameter int DELAY_DEPTH  = 131072
) (
    input  logic                clk,
    input  logic                rst_n,
    input  afx_pkg::cfg_t       cfg,
    input  afx_pkg::ctrl_t      ctrl,
    input  logic signed [15:0]  sample_in,
    input  logic                start_of_clip,
    input  logic                end_of_clip,
    output logic signed [15:0]  sample_out,
    output logic                last_out,
    output logic                out_valid,
    input  logic                out_stall,
    output logic                out_hold
);

    localparam int CH_W   = (MAX_CHANNELS > 1) ? $clog2(MAX_CHANNELS) : 1;
    localparam int ADDR_W = $clog2(DELAY_DEPTH);
    localparam int SEEN_W = $clog2(DELAY_DEPTH + 1);
    localparam int CMP_W  = (SEEN_W > 18) ? SEEN_W : 18;
    localparam int EXT_W  = CMP_W + 1;

    // Per-channel low-pass state
    logic signed [23:0] lp_level_reg [MAX_CHANNELS];
    logic signed [23:0] prev_lp_reg  [MAX_CHANNELS];

    logic [CH_W-1:0]    chan_reg;
    logic [CH_W-1:0]    chan_next;
    logic [SEEN_W-1:0]  seen_reg;
    logic [SEEN_W-1:0]  seen_next;
    logic [ADDR_W-1:0]  wp_reg;
    logic [ADDR_W-1:0]  wp_next;
    logic               out_valid_reg;

    // Payload registers
    logic signed [15:0] x_reg;
    logic               eoc_reg;
    logic signed [42:0] prod_reg;
    logic [15:0]        echo_q_reg;
    logic               hit_reg;
    logic signed [15:0] sample_out_reg;
    logic               last_out_reg;

    logic [15:0]        echo_mem [DELAY_DEPTH];

    logic [3:0]         count_eff;
    logic [3:0]         chan_ext;
    logic [3:0]         chan_sel4;
    logic [3:0]         chan_inc4;
    logic [CH_W-1:0]    ch;
    logic signed [23:0] lp_cur;
    logic signed [23:0] prev_cur;
    logic [13:0]        frames;
    logic signed [24:0] mul_a;
    logic signed [17:0] mul_b;
    logic signed [42:0] rnd_lp;
    logic signed [26:0] lp_sum;
    logic signed [23:0] lp_new;
    logic [CMP_W-1:0]   delay_raw;
    logic [CMP_W-1:0]   delay_sat;
    logic               hit;
    logic [EXT_W-1:0]   wp_ext;
    logic [EXT_W-1:0]   dly_ext;
    logic [EXT_W-1:0]   rd_wide;
    logic [ADDR_W-1:0]  rd_addr;
    logic signed [42:0] y_full;
    logic signed [15:0] y16;

    // Channel selection: count clamped to 1..MAX_CHANNELS, stale index maps to zero
    always_comb
    begin
        if (cfg.channel_count == 4'd0)
        begin
            count_eff = 4'd1;
        end
        else if (cfg.channel_count > 4'(MAX_CHANNELS))
        begin
            count_eff = 4'(MAX_CHANNELS);
        end
        else
        begin
            count_eff = cfg.channel_count;
        end
        chan_ext  = 4'(chan_reg);
        chan_sel4 = (chan_ext >= count_eff) ? 4'd0 : chan_ext;
        chan_inc4 = chan_sel4 + 4'd1;
        ch        = chan_sel4[CH_W-1:0];
        chan_next = (chan_inc4 >= count_eff) ? '0 : chan_inc4[CH_W-1:0];
    end

    assign lp_cur   = lp_level_reg[ch];
    assign prev_cur = prev_lp_reg[ch];
    assign frames   = (cfg.sample_rate[16:3] == 14'd0) ? 14'd1 : cfg.sample_rate[16:3];

    // Shared multiplier operand selection
    always_comb
    begin
        unique case (ctrl.mul_sel)
            afx_pkg::MUL_ALPHA_PHONE:
            begin
                mul_a = $signed({x_reg[15], x_reg, 8'd0}) - $signed({lp_cur[23], lp_cur});
                mul_b = $signed(afx_pkg::ALPHA_PHONE);
            end
            afx_pkg::MUL_ALPHA_WATER:
            begin
                mul_a = $signed({x_reg[15], x_reg, 8'd0}) - $signed({lp_cur[23], lp_cur});
                mul_b = $signed(afx_pkg::ALPHA_WATER);
            end
            afx_pkg::MUL_GAIN_PHONE:
            begin
                mul_a = $signed({lp_cur[23], lp_cur}) - $signed({prev_cur[23], prev_cur});
                mul_b = $signed(afx_pkg::GAIN_PHONE);
            end
            afx_pkg::MUL_FRAMES:
            begin
                mul_a = $signed({11'd0, frames});
                mul_b = $signed({14'd0, count_eff});
            end
            afx_pkg::MUL_GAIN_CAVE:
            begin
                mul_a = hit_reg ? $signed({{9{echo_q_reg[15]}}, echo_q_reg}) : 25'sd0;
                mul_b = $signed(afx_pkg::GAIN_CAVE);
            end
            default:
            begin
                mul_a = 25'sd0;
                mul_b = 18'sd0;
            end
        endcase
    end

    // Low-pass update from the registered product
    always_comb
    begin
        rnd_lp = (prod_reg + 43'sd8192) >>> 14;
        lp_sum = $signed({{3{lp_cur[23]}}, lp_cur}) + rnd_lp[26:0];
        if (lp_sum > afx_pkg::LP_MAX)
        begin
            lp_new = afx_pkg::LP_MAX[23:0];
        end
        else if (lp_sum < afx_pkg::LP_MIN)
        begin
            lp_new = afx_pkg::LP_MIN[23:0];
        end
        else
        begin
            lp_new = lp_sum[23:0];
        end
    end

    // Echo read address: delay saturated to the memory depth, ring wrap
    always_comb
    begin
        delay_raw = CMP_W'(prod_reg[17:0]);
        delay_sat = (delay_raw > CMP_W'(DELAY_DEPTH)) ? CMP_W'(DELAY_DEPTH) : delay_raw;
        hit       = (CMP_W'(seen_reg) >= delay_sat);
        wp_ext    = EXT_W'(wp_reg);
        dly_ext   = EXT_W'(delay_sat);
        if (wp_ext >= dly_ext)
        begin
            rd_wide = wp_ext - dly_ext;
        end
        else
        begin
            rd_wide = wp_ext + EXT_W'(DELAY_DEPTH) - dly_ext;
        end
        rd_addr = rd_wide[ADDR_W-1:0];
    end

    // Result of the finishing step
    always_comb
    begin
        unique case (ctrl.alu_op)
            afx_pkg::ALU_Y_PHONE:
            begin
                y_full = (prod_reg + 43'sd2097152) >>> 22;
            end
            afx_pkg::ALU_Y_WATER:
            begin
                y_full = ($signed({{19{lp_cur[23]}}, lp_cur}) + 43'sd128) >>> 8;
            end
            afx_pkg::ALU_Y_CAVE:
            begin
                y_full = ($signed({{13{x_reg[15]}}, x_reg, 14'd0}) + prod_reg + 43'sd8192)
                         >>> 14;
            end
            default:
            begin
                y_full = $signed({{27{x_reg[15]}}, x_reg});
            end
        endcase
        y16 = afx_pkg::sat16(y_full);
    end

    // Ring pointer and history count
    assign wp_next   = (wp_reg == ADDR_W'(DELAY_DEPTH - 1)) ? '0 : wp_reg + 1'b1;
    assign seen_next = (seen_reg < SEEN_W'(DELAY_DEPTH)) ? seen_reg + 1'b1 : seen_reg;

    // Filter state and sequencing counters
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            for (int i = 0; i < MAX_CHANNELS; i++)
            begin
                lp_level_reg[i] <= '0;
                prev_lp_reg[i]  <= '0;
            end
            chan_reg      <= '0;
            seen_reg      <= '0;
            wp_reg        <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            // start marker clears channel state before the sample is processed
            if (ctrl.accept && start_of_clip)
            begin
                for (int i = 0; i < MAX_CHANNELS; i++)
                begin
                    lp_level_reg[i] <= '0;
                    prev_lp_reg[i]  <= '0;
                end
                chan_reg <= '0;
                seen_reg <= '0;
            end
            else
            begin
                if (ctrl.alu_op == afx_pkg::ALU_LP_UPDATE)
                begin
                    lp_level_reg[ch] <= lp_new;
                end
                if (ctrl.mul_sel == afx_pkg::MUL_GAIN_PHONE)
                begin
                    prev_lp_reg[ch] <= lp_cur;
                end
                if (ctrl.commit)
                begin
                    chan_reg <= chan_next;
                    seen_reg <= seen_next;
                end
            end
            if (ctrl.commit)
            begin
                wp_reg <= wp_next;
            end
            // output register: loaded on commit, emptied when taken
            if (ctrl.commit)
            begin
                out_valid_reg <= 1'b1;
            end
            else if (!out_stall)
            begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    // Payload registers
    always_ff @(posedge clk)
    begin
        if (ctrl.accept)
        begin
            x_reg   <= sample_in;
            eoc_reg <= end_of_clip;
        end
        if (ctrl.mul_sel != afx_pkg::MUL_NONE)
        begin
            prod_reg <= mul_a * mul_b;
        end
        if (ctrl.alu_op == afx_pkg::ALU_ECHO_READ)
        begin
            hit_reg <= hit;
        end
        if (ctrl.commit)
        begin
            sample_out_reg <= y16;
            last_out_reg   <= eoc_reg;
        end
    end

    // Echo memory: one write, one registered read
    always_ff @(posedge clk)
    begin
        if (ctrl.commit)
        begin
            echo_mem[wp_reg] <= y16;
        end
        if (ctrl.alu_op == afx_pkg::ALU_ECHO_READ)
        begin
            echo_q_reg <= echo_mem[rd_addr];
        end
    end

    assign sample_out = sample_out_reg;
    assign last_out   = last_out_reg;
    assign out_valid  = out_valid_reg;
    assign out_hold   = out_valid_reg && out_stall;

endmodule

// File: rtl/audio_effect_filter_top.sv
// Top level of the audio effect filter: configuration registers, sequencer
// and datapath. Depends on afx_pkg, afx_sequencer and afx_datapath.
//
//  channel  | signals                                  | moves
//  ---------+------------------------------------------+-------------------------
//  input    | in_valid, in_stall, sample_in,           | one sample per transaction
//           | start_of_clip, end_of_clip               |
//  output   | out_valid, out_stall, sample_out,        | one sample per transaction
//           | last_out                                 |
//  config   | cfg_write, cfg_index, cfg_data           | one register write per cycle
//
// Each mode runs its own microprogram routine through the one shared
// multiplier, and the routine of the mode sets how long a transaction takes.
// A finishing step waits while the output register still holds an untaken
// result; the next input is taken as soon as the sequencer is back at dispatch.
// Reset is asynchronous, active low; the echo memory has no clearing pass, as
// history reads are gated by the sample count since the clip start.
module audio_effect_filter_top #(
    parameter int MAX_CHANNELS = 8,
    parameter int DELAY_DEPTH  = 131072
) (
    input  logic                clk,
    input  logic                rst_n,
    input  logic                cfg_write,
    input  logic [1:0]          cfg_index,
    input  logic [16:0]         cfg_data,
    input  logic                in_valid,
    output logic                in_stall,
    input  logic signed [15:0]  sample_in,
    input  logic                start_of_clip,
    input  logic                end_of_clip,
    output logic                out_valid,
    input  logic                out_stall,
    output logic signed [15:0]  sample_out,
    output logic                last_out
);

    afx_pkg::cfg_t   cfg_reg;
    afx_pkg::ctrl_t  ctrl;
    logic            out_hold;

    // Configuration registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg.filter_mode   <= afx_pkg::RST_FILTER_MODE;
            cfg_reg.channel_count <= afx_pkg::RST_CHANNEL_COUNT;
            cfg_reg.sample_rate   <= afx_pkg::RST_SAMPLE_RATE;
        end
        else if (cfg_write)
        begin
            unique case (cfg_index)
                afx_pkg::REG_FILTER_MODE:   cfg_reg.filter_mode   <= cfg_data[1:0];
                afx_pkg::REG_CHANNEL_COUNT: cfg_reg.channel_count <= cfg_data[3:0];
                afx_pkg::REG_SAMPLE_RATE:   cfg_reg.sample_rate   <= cfg_data;
                default:                    cfg_reg               <= cfg_reg;
            endcase
        end
    end

    afx_sequencer u_seq (
        .clk         (clk),
        .rst_n       (rst_n),
        .filter_mode (cfg_reg.filter_mode),
        .in_valid    (in_valid),
        .in_stall    (in_stall),
        .out_hold    (out_hold),
        .ctrl        (ctrl)
    );

    afx_datapath #(
        .MAX_CHANNELS (MAX_CHANNELS),
        .DELAY_DEPTH  (DELAY_DEPTH)
    ) u_dp (
        .clk           (clk),
        .rst_n         (rst_n),
        .cfg           (cfg_reg),
        .ctrl          (ctrl),
        .sample_in     (sample_in),
        .start_of_clip (start_of_clip),
        .end_of_clip   (end_of_clip),
        .sample_out    (sample_out),
        .last_out      (last_out),
        .out_valid     (out_valid),
        .out_stall     (out_stall),
        .out_hold      (out_hold)
    );

    // An accepted transaction always leaves the dispatch step
    a_busy_after_accept: assert property (@(posedge clk) disable iff (!rst_n)
        (in_valid && !in_stall) |=> in_stall)
        else $error("input taken again right after a transaction");

    // A new result appears only from a processing step
    a_result_from_work: assert property (@(posedge clk) disable iff (!rst_n)
        $rose(out_valid) |-> $past(in_stall))
        else $error("result produced without a sample in progress");

    // Mode register takes the written value
    a_mode_write: assert property (@(posedge clk) disable iff (!rst_n)
        (cfg_write && cfg_index == afx_pkg::REG_FILTER_MODE)
        |=> cfg_reg.filter_mode == $past(cfg_data[1:0]))
        else $error("filter mode write lost");

endmodule
